/* rtl/core/go_back_n_sender_window_defines.svh */
// assertion macros for the go-back-n sender window
// used by rtl files that carry concurrent checks; expects clk and rst_n in scope
`ifndef GO_BACK_N_SENDER_WINDOW_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_DEFINES_SVH

// condition holds at every edge out of reset
`define GBN_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequence holds in the same cycle as the antecedent
`define GBN_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define GBN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/gbn_pkg.sv */
// shared types, constants and helper functions of the go-back-n sender window
// no dependencies; imported by gbn_cmd_if, gbn_evt_if, gbn_div and go_back_n_sender_window
package gbn_pkg;

    // field widths
    localparam int CMD_W      = 2;
    localparam int EV_W       = 2;
    localparam int SEQ_W      = 8;
    localparam int TIME_W     = 32;
    localparam int TIMER_W    = 17;
    localparam int SUM_W      = 48;
    localparam int CNT_W      = 32;
    localparam int TO_W       = 16;
    localparam int WIN_W      = 7;
    localparam int WARM_W     = 8;
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TO    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_TO    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP      = 2'd3;

    // register reset values
    localparam logic [WIN_W-1:0]  WINDOW_RESET   = 7'd8;
    localparam logic [TO_W-1:0]   FIRST_TO_RESET = 16'd10;
    localparam logic [TO_W-1:0]   RETRY_TO_RESET = 16'd100;
    localparam logic [WARM_W-1:0] WARMUP_RESET   = 8'd10;

    // window storage depth
    localparam int MAX_WINDOW_DEF = 64;

    // sequence numbers run 0..254
    localparam logic [SEQ_W-1:0]   SEQ_LAST  = 8'd254;
    localparam logic [WARM_W-1:0]  FSD_MAX   = 8'd255;
    localparam logic [TIMER_W-1:0] TIMER_MAX = 17'h1FFFF;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OFFER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ACK   = 2'd2;

    // result event codes
    localparam logic [EV_W-1:0] EV_SEND   = 2'd0;
    localparam logic [EV_W-1:0] EV_RETX   = 2'd1;
    localparam logic [EV_W-1:0] EV_ACK    = 2'd2;
    localparam logic [EV_W-1:0] EV_REFUSE = 2'd3;

    typedef logic [SEQ_W-1:0] seq_t;

    // next sequence number modulo 255
    function automatic seq_t seq_inc(input seq_t s);
        seq_inc = (s == SEQ_LAST) ? '0 : s + 8'd1;
    endfunction

    // fixed timeouts during warmup, twice the average after it
    function automatic logic [TIMER_W-1:0] pick_timeout(
        input logic              warm,
        input logic              retry,
        input logic [TO_W-1:0]   first_to,
        input logic [TO_W-1:0]   retry_to,
        input logic [TIME_W-1:0] avg
    );
        if (warm)
            pick_timeout = retry ? {1'b0, retry_to} : {1'b0, first_to};
        else if (avg[TIME_W-1:TO_W] != '0)
            pick_timeout = TIMER_MAX;
        else
            pick_timeout = {avg[TO_W-1:0], 1'b0};
    endfunction

endpackage

/* rtl/core/gbn_cmd_if.sv */
// command channel of the go-back-n sender window: valid/ready plus payload
// depends on gbn_pkg for field widths
interface gbn_cmd_if
    import gbn_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [SEQ_W-1:0] ack_seq;

    modport source (output valid, output command, output ack_seq, input ready);
    modport sink   (input valid, input command, input ack_seq, output ready);
endinterface

/* rtl/core/gbn_evt_if.sv */
// event channel of the go-back-n sender window: valid/ready plus result payload
// depends on gbn_pkg for field widths
interface gbn_evt_if
    import gbn_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [EV_W-1:0]   event_res;
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] rtt_ms;
    logic [TIME_W-1:0] avg_rtt_ms;
    logic              last;

    modport source (output valid, output event_res, output seq, output rtt_ms,
                    output avg_rtt_ms, output last, input ready);
    modport sink   (input valid, input event_res, input seq, input rtt_ms,
                    input avg_rtt_ms, input last, output ready);
endinterface

/* rtl/core/gbn_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no package dependencies
module gbn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/core/gbn_div.sv */
// radix-2 restoring divider for the running round-trip average
// depends on gbn_pkg; one quotient bit per cycle, SUM_W quotient bits per division
module gbn_div
    import gbn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] num,
    input  logic [CNT_W-1:0] den,
    output logic             done,
    output logic [SUM_W-1:0] quo
);
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     den_reg, den_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;

    logic [CNT_W:0] shifted;
    logic [CNT_W:0] diff;
    logic           ge;

    // one restoring step
    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = DIV_CNT_W'(SUM_W);
            rem_next = '0;
            den_next = den;
            quo_next = num;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

/* rtl/core/go_back_n_sender_window.sv */
// Go-Back-N sender window: takes tick, offer and ack commands and reports sends,
// retransmits, accepted acks and refusals; send times live in a MAX_WINDOW-entry
// ram read while idle, ahead of the command. One command is worked on at a time: a
// tick, offer, refused or unknown command passes the idle and exec states, an accepted
// ack also the div state, where the radix-2 divider forms the average round trip, and
// the ackfin state; an expiring tick walks the retx state, one packet per step.
// A result waits in an output register while the next command is taken in.
// Depends on gbn_pkg, gbn_cmd_if, gbn_evt_if, gbn_ram, gbn_div and the defines header.
`include "go_back_n_sender_window_defines.svh"

module go_back_n_sender_window
    import gbn_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    gbn_cmd_if.sink               cmd,
    gbn_evt_if.source             evt,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int OW = $clog2(MAX_WINDOW + 1);
    localparam int SW = OW + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_ACKFIN = 3'd3;
    localparam logic [2:0] S_RETX   = 3'd4;

    // configuration registers
    logic [WIN_W-1:0]  win_cfg_reg;
    logic [TO_W-1:0]   first_to_reg;
    logic [TO_W-1:0]   retry_to_reg;
    logic [WARM_W-1:0] warmup_reg;

    // control and window state
    logic [2:0]         state_reg, state_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [SEQ_W-1:0]   ack_reg, ack_next;
    logic [SEQ_W-1:0]   base_seq_reg, base_seq_next;
    logic [SEQ_W-1:0]   next_seq_reg, next_seq_next;
    logic [OW-1:0]      outstanding_reg, outstanding_next;
    logic [WARM_W-1:0]  fsd_reg, fsd_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [AW-1:0]      base_slot_reg, base_slot_next;
    logic [SUM_W-1:0]   rtt_sum_reg, rtt_sum_next;
    logic [CNT_W-1:0]   acked_reg, acked_next;
    logic [TIME_W-1:0]  avg_reg, avg_next;
    logic [TIME_W-1:0]  rtt_reg, rtt_next;
    logic [OW-1:0]      walk_cnt_reg, walk_cnt_next;
    logic [SEQ_W-1:0]   walk_seq_reg, walk_seq_next;

    // output register
    logic              ovalid_reg;
    logic [EV_W-1:0]   oev_reg;
    logic [SEQ_W-1:0]  oseq_reg;
    logic [TIME_W-1:0] ortt_reg;
    logic [TIME_W-1:0] oavg_reg;
    logic              olast_reg;

    // result to load
    logic              emit_en;
    logic [EV_W-1:0]   emit_ev;
    logic [SEQ_W-1:0]  emit_seq;
    logic [TIME_W-1:0] emit_rtt;
    logic              emit_last;

    // ram and divider hookup
    logic              ram_we, ram_re;
    logic [AW-1:0]     slot;
    logic [TIME_W-1:0] ram_rdata;
    logic              div_start, div_done;
    logic [SUM_W-1:0]  div_quo;

    // helpers
    logic               out_free;
    logic               cmd_xfer;
    logic [OW-1:0]      win_eff;
    logic               warm;
    logic [SW-1:0]      slot_sum;
    logic [TIMER_W-1:0] tdec;
    logic [SUM_W:0]     sum_wide;
    logic [TIME_W-1:0]  rtt_meas;
    logic [AW:0]        slot_inc;

    assign out_free = !ovalid_reg || evt.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign warm      = (fsd_reg < warmup_reg);
    assign win_eff   = (int'(win_cfg_reg) > MAX_WINDOW) ? OW'(MAX_WINDOW) : OW'(win_cfg_reg);
    assign slot_sum  = SW'(base_slot_reg) + SW'(outstanding_reg);
    assign slot      = (slot_sum >= SW'(MAX_WINDOW)) ? AW'(slot_sum - SW'(MAX_WINDOW))
                                                     : AW'(slot_sum);
    assign slot_inc  = {1'b0, base_slot_reg} + (AW+1)'(1);
    assign tdec      = (timer_reg == '0) ? '0 : timer_reg - TIMER_W'(1);
    assign rtt_meas  = now_reg - ram_rdata;
    assign sum_wide  = {1'b0, rtt_sum_reg} + (SUM_W+1)'(rtt_meas);
    assign ram_re    = (state_reg == S_IDLE);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_cfg_reg  <= WINDOW_RESET;
            first_to_reg <= FIRST_TO_RESET;
            retry_to_reg <= RETRY_TO_RESET;
            warmup_reg   <= WARMUP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_SIZE: win_cfg_reg  <= cfg_data[WIN_W-1:0];
                CFG_FIRST_TO:    first_to_reg <= cfg_data[TO_W-1:0];
                CFG_RETRY_TO:    retry_to_reg <= cfg_data[TO_W-1:0];
                CFG_WARMUP:      warmup_reg   <= cfg_data[WARM_W-1:0];
                default:         win_cfg_reg  <= win_cfg_reg;
            endcase
        end
    end

    // command sequencer: read-modify-write of window state and send-time ram
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        ack_next         = ack_reg;
        base_seq_next    = base_seq_reg;
        next_seq_next    = next_seq_reg;
        outstanding_next = outstanding_reg;
        fsd_next         = fsd_reg;
        now_next         = now_reg;
        timer_next       = timer_reg;
        base_slot_next   = base_slot_reg;
        rtt_sum_next     = rtt_sum_reg;
        acked_next       = acked_reg;
        avg_next         = avg_reg;
        rtt_next         = rtt_reg;
        walk_cnt_next    = walk_cnt_reg;
        walk_seq_next    = walk_seq_reg;
        ram_we           = 1'b0;
        div_start        = 1'b0;
        emit_en          = 1'b0;
        emit_ev          = EV_REFUSE;
        emit_seq         = '0;
        emit_rtt         = '0;
        emit_last        = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    cmd_next   = cmd.command;
                    ack_next   = cmd.ack_seq;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    case (cmd_reg)
                        CMD_TICK:
                        begin
                            now_next = now_reg + TIME_W'(1);
                            if (outstanding_reg != '0)
                            begin
                                if (tdec == '0)
                                begin
                                    timer_next    = pick_timeout(warm, 1'b1, first_to_reg,
                                                                 retry_to_reg, avg_reg);
                                    walk_cnt_next = '0;
                                    walk_seq_next = base_seq_reg;
                                    state_next    = S_RETX;
                                end
                                else
                                begin
                                    timer_next = tdec;
                                end
                            end
                        end

                        CMD_OFFER:
                        begin
                            emit_en = 1'b1;
                            if (outstanding_reg < win_eff)
                            begin
                                ram_we = 1'b1;
                                if (outstanding_reg == '0)
                                begin
                                    timer_next = pick_timeout(warm, 1'b0, first_to_reg,
                                                              retry_to_reg, avg_reg);
                                end
                                outstanding_next = outstanding_reg + OW'(1);
                                if (fsd_reg != FSD_MAX)
                                begin
                                    fsd_next = fsd_reg + WARM_W'(1);
                                end
                                emit_ev       = EV_SEND;
                                emit_seq      = next_seq_reg;
                                next_seq_next = seq_inc(next_seq_reg);
                            end
                            else
                            begin
                                emit_ev  = EV_REFUSE;
                                emit_seq = next_seq_reg;
                            end
                        end

                        CMD_ACK:
                        begin
                            if (outstanding_reg != '0 && ack_reg == base_seq_reg)
                            begin
                                rtt_next     = rtt_meas;
                                rtt_sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
                                acked_next   = (acked_reg == '1) ? acked_reg
                                                                 : acked_reg + CNT_W'(1);
                                div_start    = 1'b1;
                                state_next   = S_DIV;
                            end
                            else
                            begin
                                emit_en  = 1'b1;
                                emit_ev  = EV_REFUSE;
                                emit_seq = ack_reg;
                            end
                        end

                        default:
                        begin
                            emit_en  = 1'b1;
                            emit_ev  = EV_REFUSE;
                            emit_seq = '0;
                        end
                    endcase
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = (div_quo[SUM_W-1:TIME_W] != '0) ? '1 : div_quo[TIME_W-1:0];
                    state_next = S_ACKFIN;
                end
            end

            S_ACKFIN:
            begin
                if (out_free)
                begin
                    outstanding_next = outstanding_reg - OW'(1);
                    base_slot_next   = (slot_inc == (AW+1)'(MAX_WINDOW)) ? '0
                                                                         : slot_inc[AW-1:0];
                    base_seq_next    = seq_inc(base_seq_reg);
                    timer_next       = (outstanding_reg > OW'(1))
                                       ? pick_timeout(warm, 1'b0, first_to_reg,
                                                      retry_to_reg, avg_reg)
                                       : '0;
                    emit_en          = 1'b1;
                    emit_ev          = EV_ACK;
                    emit_seq         = ack_reg;
                    emit_rtt         = rtt_reg;
                    state_next       = S_IDLE;
                end
            end

            S_RETX:
            begin
                if (out_free)
                begin
                    emit_en       = 1'b1;
                    emit_ev       = EV_RETX;
                    emit_seq      = walk_seq_reg;
                    emit_last     = ((walk_cnt_reg + OW'(1)) == outstanding_reg);
                    walk_seq_next = seq_inc(walk_seq_reg);
                    walk_cnt_next = walk_cnt_reg + OW'(1);
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            base_seq_reg    <= '0;
            next_seq_reg    <= '0;
            outstanding_reg <= '0;
            fsd_reg         <= '0;
            now_reg         <= '0;
            timer_reg       <= '0;
            base_slot_reg   <= '0;
            rtt_sum_reg     <= '0;
            acked_reg       <= '0;
            avg_reg         <= '0;
            ovalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            base_seq_reg    <= base_seq_next;
            next_seq_reg    <= next_seq_next;
            outstanding_reg <= outstanding_next;
            fsd_reg         <= fsd_next;
            now_reg         <= now_next;
            timer_reg       <= timer_next;
            base_slot_reg   <= base_slot_next;
            rtt_sum_reg     <= rtt_sum_next;
            acked_reg       <= acked_next;
            avg_reg         <= avg_next;
            if (emit_en)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (evt.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        ack_reg      <= ack_next;
        rtt_reg      <= rtt_next;
        walk_cnt_reg <= walk_cnt_next;
        walk_seq_reg <= walk_seq_next;
        if (emit_en)
        begin
            oev_reg   <= emit_ev;
            oseq_reg  <= emit_seq;
            ortt_reg  <= emit_rtt;
            oavg_reg  <= avg_reg;
            olast_reg <= emit_last;
        end
    end

    // send-time store, one entry per window slot
    gbn_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_WINDOW)
    ) u_send_time (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (now_reg),
        .re    (ram_re),
        .raddr (base_slot_reg),
        .rdata (ram_rdata)
    );

    // running average divider
    gbn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (rtt_sum_next),
        .den   (acked_next),
        .done  (div_done),
        .quo   (div_quo)
    );

    // event channel drive
    assign evt.valid      = ovalid_reg;
    assign evt.event_res  = oev_reg;
    assign evt.seq        = oseq_reg;
    assign evt.rtt_ms     = ortt_reg;
    assign evt.avg_rtt_ms = oavg_reg;
    assign evt.last       = olast_reg;

    // checks
    `GBN_ASSERT_ALWAYS(a_window_bound, int'(outstanding_reg) <= MAX_WINDOW, "window overrun")
    `GBN_ASSERT_IMPLY(a_timer_idle, outstanding_reg == '0, timer_reg == '0, "timer live on empty window")
    `GBN_ASSERT_IMPLY(a_ram_port, ram_we, !ram_re, "send-time write collides with read")
    `GBN_ASSERT_IMPLY(a_div_owner, div_done, state_reg == S_DIV, "divider result outside ack path")
    `GBN_ASSERT_IMPLY(a_retx_nonempty, state_reg == S_RETX, outstanding_reg != '0, "retransmit walk on empty window")
endmodule

/* bench/testbench.sv */
// self-checking bench for go_back_n_sender_window: directed table, then random phases
// depends on gbn_pkg, gbn_cmd_if, gbn_evt_if and the rtl of the block
`timescale 1ns / 1ps

module testbench
    import gbn_pkg::*;
;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam int SETTLE_CYCLES = 64;
    localparam int PRINT_CAP = 50;

    // one result as the block reports it
    typedef struct {
        logic [EV_W-1:0]   ev;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] rtt;
        logic [TIME_W-1:0] avg;
        logic              last;
    } window_event_t;

    // one line of the directed table
    typedef struct packed {
        logic                  is_cfg;
        logic [CMD_W-1:0]      op;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] arg;
        logic [5:0]            reps;
        logic                  to_oldest;
        logic                  typed;
        logic [EV_W-1:0]       want_ev;
        logic [SEQ_W-1:0]      want_seq;
    } script_row_t;

    // register setting and length of one random phase
    typedef struct {
        logic [WIN_W-1:0]  win;
        logic [TO_W-1:0]   first_to;
        logic [TO_W-1:0]   retry_to;
        logic [WARM_W-1:0] warm;
        int                items;
    } phase_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gbn_cmd_if cmd_if ();
    gbn_evt_if evt_if ();

    go_back_n_sender_window dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .evt       (evt_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // shadow registers
    logic [WIN_W-1:0]  win_size;
    logic [TO_W-1:0]   first_to;
    logic [TO_W-1:0]   retry_to;
    logic [WARM_W-1:0] warm_sends;

    // shadow window state
    logic [SEQ_W-1:0]   oldest_seq;
    logic [SEQ_W-1:0]   next_seq;
    logic [WIN_W-1:0]   in_flight;
    logic [WARM_W-1:0]  sends_done;
    logic [TIME_W-1:0]  clock_ms;
    logic [TIMER_W-1:0] guard_timer;
    logic [TIME_W-1:0]  sent_at [64];
    logic [5:0]         oldest_slot;
    logic [SUM_W-1:0]   rtt_total;
    logic [CNT_W-1:0]   acks_seen;
    logic [TIME_W-1:0]  avg_rtt;

    window_event_t due_events [$];
    window_event_t head;
    int mismatches = 0;
    int items_sent = 0;
    int sink_hold = 0;
    int sink_calm = 0;
    int source_calm = 0;

    script_row_t script [20];
    phase_t plan [5] = '{
        '{7'd8,   16'd4,     16'd9,     8'd20,  80},
        '{7'd64,  16'd3,     16'd2,     8'd255, 85},
        '{7'd1,   16'd65535, 16'd1,     8'd0,   50},
        '{7'd127, 16'd1,     16'd65535, 8'd128, 80},
        '{7'd3,   16'd2,     16'd5,     8'd10,  55}
    };

    function automatic logic [SEQ_W-1:0] bump_seq(input logic [SEQ_W-1:0] s);
        return (s == 8'd254) ? 8'd0 : s + 8'd1;
    endfunction

    // fixed values during warmup, twice the average after it
    function automatic logic [TIMER_W-1:0] timeout_for(input bit retry);
        logic [TIME_W:0] doubled;
        if (sends_done < warm_sends)
            return retry ? {1'b0, retry_to} : {1'b0, first_to};
        doubled = {avg_rtt, 1'b0};
        return (doubled > 33'd131071) ? 17'h1FFFF : doubled[TIMER_W-1:0];
    endfunction

    function automatic void queue_result(input logic [EV_W-1:0] ev,
                                         input logic [SEQ_W-1:0] seq,
                                         input logic [TIME_W-1:0] rtt);
        window_event_t r;
        r.ev = ev;
        r.seq = seq;
        r.rtt = rtt;
        r.avg = avg_rtt;
        r.last = 1'b0;
        due_events.push_back(r);
    endfunction

    // predicted results of one accepted command, window state moved on
    function automatic void advance_window(input logic [CMD_W-1:0] op,
                                           input logic [SEQ_W-1:0] ack);
        int n;
        logic [WIN_W-1:0]  eff;
        logic [SEQ_W-1:0]  s;
        logic [5:0]        slot;
        logic [TIME_W-1:0] rtt;
        logic [SUM_W:0]    sum;
        logic [SUM_W-1:0]  quot;
        n = 0;
        eff = (win_size > 7'd64) ? 7'd64 : win_size;
        case (op)
            CMD_TICK:
            begin
                clock_ms = clock_ms + 32'd1;
                if (in_flight != 0)
                begin
                    if (guard_timer != 0)
                        guard_timer = guard_timer - 17'd1;
                    // expiry: resend the whole window, oldest first
                    if (guard_timer == 0)
                    begin
                        s = oldest_seq;
                        for (int k = 0; k < in_flight; k++)
                        begin
                            queue_result(EV_RETX, s, '0);
                            n++;
                            s = bump_seq(s);
                        end
                        guard_timer = timeout_for(1'b1);
                    end
                end
            end
            CMD_OFFER:
            begin
                if (in_flight < eff)
                begin
                    slot = oldest_slot + in_flight[5:0];
                    sent_at[slot] = clock_ms;
                    if (in_flight == 0)
                        guard_timer = timeout_for(1'b0);
                    in_flight = in_flight + 7'd1;
                    if (sends_done != 8'd255)
                        sends_done = sends_done + 8'd1;
                    queue_result(EV_SEND, next_seq, '0);
                    next_seq = bump_seq(next_seq);
                end
                else
                    queue_result(EV_REFUSE, next_seq, '0);
                n++;
            end
            CMD_ACK:
            begin
                if (in_flight != 0 && ack == oldest_seq)
                begin
                    rtt = clock_ms - sent_at[oldest_slot];
                    sum = {1'b0, rtt_total} + rtt;
                    rtt_total = sum[SUM_W] ? '1 : sum[SUM_W-1:0];
                    if (acks_seen != '1)
                        acks_seen = acks_seen + 32'd1;
                    quot = rtt_total / acks_seen;
                    avg_rtt = (quot > 48'h0000_FFFF_FFFF) ? '1 : quot[TIME_W-1:0];
                    in_flight = in_flight - 7'd1;
                    oldest_slot = oldest_slot + 6'd1;
                    oldest_seq = bump_seq(oldest_seq);
                    guard_timer = (in_flight != 0) ? timeout_for(1'b0) : '0;
                    queue_result(EV_ACK, ack, rtt);
                end
                else
                    queue_result(EV_REFUSE, ack, '0);
                n++;
            end
            default:
            begin
                queue_result(EV_REFUSE, '0, '0);
                n++;
            end
        endcase
        if (n > 0)
            due_events[due_events.size() - 1].last = 1'b1;
    endfunction

    function automatic void reset_window();
        win_size = WINDOW_RESET;
        first_to = FIRST_TO_RESET;
        retry_to = RETRY_TO_RESET;
        warm_sends = WARMUP_RESET;
        oldest_seq = '0;
        next_seq = '0;
        in_flight = '0;
        sends_done = '0;
        clock_ms = '0;
        guard_timer = '0;
        oldest_slot = '0;
        rtt_total = '0;
        acks_seen = '0;
        avg_rtt = '0;
    endfunction

    // mostly short gaps, a few long ones, now and then a calm stretch
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            calm = $urandom_range(20, 60);
        if (r < 45)
            return 0;
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(15, 30);
    endfunction

    function automatic script_row_t cmd_row(input logic [CMD_W-1:0] op,
                                            input int arg, input int reps,
                                            input bit to_oldest);
        script_row_t r;
        r = '0;
        r.op = op;
        r.arg = CFG_DATA_W'(arg);
        r.reps = 6'(reps);
        r.to_oldest = to_oldest;
        return r;
    endfunction

    function automatic script_row_t typed_row(input logic [CMD_W-1:0] op,
                                              input int arg,
                                              input logic [EV_W-1:0] ev,
                                              input int seq);
        script_row_t r;
        r = cmd_row(op, arg, 1, 1'b0);
        r.typed = 1'b1;
        r.want_ev = ev;
        r.want_seq = SEQ_W'(seq);
        return r;
    endfunction

    function automatic script_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input int data);
        script_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.arg = CFG_DATA_W'(data);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
        if (mismatches < PRINT_CAP)
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // one command transfer; a typed row overrides the predicted result
    task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [SEQ_W-1:0] ack,
                            input bit typed, input logic [EV_W-1:0] want_ev,
                            input logic [SEQ_W-1:0] want_seq);
        int gap;
        int depth;
        window_event_t r;
        cmd_if.valid <= 1'b1;
        cmd_if.command <= op;
        cmd_if.ack_seq <= ack;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        depth = due_events.size();
        advance_window(op, ack);
        if (typed)
        begin
            while (due_events.size() > depth)
                void'(due_events.pop_back());
            r.ev = want_ev;
            r.seq = want_seq;
            r.rtt = '0;
            r.avg = '0;
            r.last = 1'b1;
            due_events.push_back(r);
        end
        items_sent++;
        gap = pick_gap(source_calm);
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send(input logic [CMD_W-1:0] op, input logic [SEQ_W-1:0] ack);
        push_cmd(op, ack, 1'b0, EV_SEND, '0);
    endtask

    // drain the results, then give a quiet tick time to finish
    task automatic settle();
        cmd_if.valid <= 1'b0;
        while (due_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_WINDOW_SIZE: win_size = data[WIN_W-1:0];
            CFG_FIRST_TO:    first_to = data;
            CFG_RETRY_TO:    retry_to = data;
            default:         warm_sends = data[WARM_W-1:0];
        endcase
    endtask

    // one random phase: offer bursts, ticks and in-order acks, with some noise
    task automatic run_phase(input phase_t ph);
        int target;
        int burst;
        int ticks;
        int acks;
        int eff;
        target = items_sent + ph.items;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                eff = (win_size > 7'd64) ? 64 : win_size;
                if ($urandom_range(0, 9) == 0)
                    burst = eff + 1;
                else
                    burst = $urandom_range(1, (eff < 6) ? eff + 1 : 6);
                repeat (burst) send(CMD_OFFER, SEQ_W'($urandom_range(0, 255)));
                ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 6);
                repeat (ticks) send(CMD_TICK, SEQ_W'($urandom_range(0, 255)));
                acks = $urandom_range(0, in_flight);
                repeat (acks)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send(CMD_ACK, SEQ_W'($urandom_range(0, 255)));
                    send(CMD_ACK, oldest_seq);
                end
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: send(CMD_ACK, SEQ_W'($urandom_range(0, 255)));
                    1: send(CMD_UNKNOWN, SEQ_W'($urandom_range(0, 255)));
                    2: send(CMD_TICK, SEQ_W'($urandom_range(0, 255)));
                    default: send(CMD_OFFER, SEQ_W'($urandom_range(0, 255)));
                endcase
            end
        end
    endtask

    // result sink with random stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            evt_if.ready <= 1'b0;
        else if (sink_hold > 0)
        begin
            evt_if.ready <= 1'b0;
            sink_hold--;
        end
        else
        begin
            evt_if.ready <= 1'b1;
            sink_hold = pick_gap(sink_calm);
        end
    end

    // compare each result transfer with the oldest one due
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && evt_if.valid === 1'b1 && evt_if.ready === 1'b1)
        begin
            if (due_events.size() == 0)
                note_mismatch("transfer with nothing due, seq", TIME_W'(evt_if.seq), '0);
            else
            begin
                head = due_events.pop_front();
                if (evt_if.event_res !== head.ev)
                    note_mismatch("event_res", TIME_W'(evt_if.event_res), TIME_W'(head.ev));
                if (evt_if.seq !== head.seq)
                    note_mismatch("seq", TIME_W'(evt_if.seq), TIME_W'(head.seq));
                if (evt_if.rtt_ms !== head.rtt)
                    note_mismatch("rtt_ms", evt_if.rtt_ms, head.rtt);
                if (evt_if.avg_rtt_ms !== head.avg)
                    note_mismatch("avg_rtt_ms", evt_if.avg_rtt_ms, head.avg);
                if (evt_if.last !== head.last)
                    note_mismatch("last", TIME_W'(evt_if.last), TIME_W'(head.last));
            end
        end
    end

    // run guard
    initial
    begin
        #100_000_000;
        $display("status: fail");
        $finish;
    end

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.command = CMD_TICK;
        cmd_if.ack_seq = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_WINDOW_SIZE;
        cfg_data = '0;
        reset_window();

        // defaults first, then a two-deep window with a zero timeout,
        // a closed window, an oversize one and the rtt-based timeout
        script = '{
            typed_row(CMD_UNKNOWN, 0, EV_REFUSE, 0),
            typed_row(CMD_ACK, 254, EV_REFUSE, 254),
            typed_row(CMD_ACK, 255, EV_REFUSE, 255),
            cmd_row(CMD_TICK, 0, 1, 1'b0),
            cfg_row(CFG_WINDOW_SIZE, 2),
            cfg_row(CFG_FIRST_TO, 0),
            typed_row(CMD_OFFER, 0, EV_SEND, 0),
            typed_row(CMD_OFFER, 255, EV_SEND, 1),
            typed_row(CMD_OFFER, 0, EV_REFUSE, 2),
            typed_row(CMD_ACK, 1, EV_REFUSE, 1),
            cmd_row(CMD_TICK, 0, 1, 1'b0),
            cmd_row(CMD_ACK, 0, 3, 1'b1),
            cfg_row(CFG_WINDOW_SIZE, 0),
            cmd_row(CMD_OFFER, 0, 1, 1'b0),
            cfg_row(CFG_WINDOW_SIZE, 127),
            cfg_row(CFG_WARMUP, 0),
            cfg_row(CFG_RETRY_TO, 65535),
            cmd_row(CMD_OFFER, 0, 2, 1'b0),
            cmd_row(CMD_TICK, 0, 2, 1'b0),
            cmd_row(CMD_ACK, 0, 2, 1'b1)
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                settle();
                write_reg(script[i].reg_idx, script[i].arg);
            end
            else
            begin
                repeat (script[i].reps)
                    push_cmd(script[i].op,
                             script[i].to_oldest ? oldest_seq : script[i].arg[SEQ_W-1:0],
                             script[i].typed, script[i].want_ev, script[i].want_seq);
            end
        end

        // random phases, each under its own register setting
        foreach (plan[p])
        begin
            settle();
            write_reg(CFG_WINDOW_SIZE, CFG_DATA_W'(plan[p].win));
            write_reg(CFG_FIRST_TO, plan[p].first_to);
            write_reg(CFG_RETRY_TO, plan[p].retry_to);
            write_reg(CFG_WARMUP, CFG_DATA_W'(plan[p].warm));
            run_phase(plan[p]);
        end

        settle();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
